@@ rtl/core/best_first_quadtree_pattern_queue_unit_assert.svh @@
// Assertion shorthands shared by the queue unit.
`ifndef BEST_FIRST_QUADTREE_PATTERN_QUEUE_UNIT_ASSERT_SVH
`define BEST_FIRST_QUADTREE_PATTERN_QUEUE_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define BFQPQ_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define BFQPQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define BFQPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bfqpq_pkg.sv @@
package bfqpq_pkg;

	localparam int QUEUE_DEPTH_DEF   = 4096;
	localparam int COORD_BITS_DEF    = 6;
	localparam int PRIORITY_BITS_DEF = 32;

	// Resolution register.
	localparam int             RES_W     = 7;
	localparam logic [RES_W-1:0] RES_RESET = 7'd64;

	// Width of the per-beat push count.
	localparam int COUNT_W = 3;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_PUSH   = 2'd1,
		OP_EXPAND = 2'd2,
		OP_POP    = 2'd3
	} op_t;

	typedef struct packed {
		logic en;
		logic load;
	} cmp_ctrl_t;

endpackage

@@ rtl/core/bfqpq_chan_if.sv @@
interface bfqpq_in_if #(
	parameter int COORD_BITS    = bfqpq_pkg::COORD_BITS_DEF,
	parameter int PRIORITY_BITS = bfqpq_pkg::PRIORITY_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               operation;
	logic [COORD_BITS-1:0]    node_u;
	logic [COORD_BITS-1:0]    node_v;
	logic [PRIORITY_BITS-1:0] priority_req;

	modport source (output valid, operation, node_u, node_v, priority_req, input ready);
	modport sink (input valid, operation, node_u, node_v, priority_req, output ready);
endinterface

interface bfqpq_out_if #(
	parameter int COORD_BITS    = bfqpq_pkg::COORD_BITS_DEF,
	parameter int PRIORITY_BITS = bfqpq_pkg::PRIORITY_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic [COORD_BITS-1:0]           out_u;
	logic [COORD_BITS-1:0]           out_v;
	logic [PRIORITY_BITS-1:0]        out_priority;
	logic                            out_valid;
	logic                            queue_empty;
	logic [bfqpq_pkg::COUNT_W-1:0]   pushed_count;
	logic                            dropped;

	modport source (
		output valid, out_u, out_v, out_priority, out_valid, queue_empty, pushed_count,
			dropped,
		input ready
	);
	modport sink (
		input valid, out_u, out_v, out_priority, out_valid, queue_empty, pushed_count,
			dropped,
		output ready
	);
endinterface

@@ rtl/core/bfqpq_ram.sv @@
module bfqpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/bfqpq_best.sv @@
module bfqpq_best #(
	parameter int EW = 44,
	parameter int PW = 32,
	parameter int IW = 13
) (
	input  logic                 clk,
	input  bfqpq_pkg::cmp_ctrl_t ctl,
	input  logic [EW-1:0]        entry,
	input  logic [IW-1:0]        idx,
	output logic [EW-1:0]        best_entry,
	output logic [IW-1:0]        win_idx,
	output logic [EW-1:0]        head_entry
);

	logic [EW-1:0] best_q;
	logic [IW-1:0] idx_q;
	logic [EW-1:0] head_q;
	logic          better;

	// Strictly greater, so the earliest of equal priorities is kept.
	assign better = entry[PW-1:0] > best_q[PW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.load) begin
				best_q <= entry;
				idx_q  <= idx;
				head_q <= entry;
			end else if (better) begin
				best_q <= entry;
				idx_q  <= idx;
			end
		end
	end

	assign best_entry = best_q;
	assign win_idx    = idx_q;
	assign head_entry = head_q;

endmodule

@@ rtl/core/best_first_quadtree_pattern_queue_unit.sv @@
// Best-first node queue for quadtree pattern search. Nodes of (u, v, priority) are kept in a
// single-port-write, single-port-read RAM of QUEUE_DEPTH entries with head and tail pointers;
// the RAM is not cleared after reset and needs no clearing pass. One request is worked on at
// a time and the request channel is not ready until it is finished. A clear or a pop of an
// empty queue goes straight to the finish state; a push writes its node in the expand state,
// and a child expansion tries each of the four children there in turn (three for the root
// node). A pop of a non-empty queue scans the live entries, since one shared comparator sees
// one entry per cycle from the RAM read port before the best slot is refilled with the head
// entry. The request channel is ready again at the same clock edge that registers the
// result. The result waits in an output register, so a new request can be taken while it is
// still pending; the following result is held back until that register has been emptied.
`include "best_first_quadtree_pattern_queue_unit_assert.svh"

module best_first_quadtree_pattern_queue_unit #(
	parameter int QUEUE_DEPTH   = bfqpq_pkg::QUEUE_DEPTH_DEF,
	parameter int COORD_BITS    = bfqpq_pkg::COORD_BITS_DEF,
	parameter int PRIORITY_BITS = bfqpq_pkg::PRIORITY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bfqpq_pkg::RES_W-1:0]  cfg_wdata,
	bfqpq_in_if.sink                     req,
	bfqpq_out_if.source                  rsp
);

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int EW     = 2 * COORD_BITS + PRIORITY_BITS;
	localparam int CMP_W  = (COORD_BITS + 1 > bfqpq_pkg::RES_W) ?
		COORD_BITS + 1 : bfqpq_pkg::RES_W;
	localparam int CW     = bfqpq_pkg::COUNT_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXPAND = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_MOVE   = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             head_q;
	logic [CNT_W-1:0]             tail_q;
	logic [bfqpq_pkg::RES_W-1:0]  res_q;
	logic [1:0]                   k_q;
	logic [CNT_W-1:0]             rd_idx_q;
	logic [CNT_W-1:0]             pend_idx_q;
	logic                         pend_q;
	logic                         first_q;

	bfqpq_pkg::op_t               op_q;
	logic [COORD_BITS-1:0]        u_q;
	logic [COORD_BITS-1:0]        v_q;
	logic [PRIORITY_BITS-1:0]     prio_q;
	logic [CW-1:0]                cnt_q;
	logic                         drop_q;
	logic                         valid_q;

	logic                         rsp_valid_q;
	logic [COORD_BITS-1:0]        rsp_u_q;
	logic [COORD_BITS-1:0]        rsp_v_q;
	logic [PRIORITY_BITS-1:0]     rsp_prio_q;
	logic                         rsp_ovalid_q;
	logic                         rsp_empty_q;
	logic [CW-1:0]                rsp_cnt_q;
	logic                         rsp_drop_q;

	logic                         accept;
	logic                         out_free;
	logic                         has_room;
	logic                         issue;

	logic [COORD_BITS:0]          cu_w;
	logic [COORD_BITS:0]          cv_w;
	logic                         keep;
	logic                         last;
	logic                         is_root;

	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [EW-1:0]                ram_wdata;
	logic [EW-1:0]                ram_rdata;

	bfqpq_pkg::cmp_ctrl_t         cmp_ctl;
	logic [EW-1:0]                best_entry;
	logic [CNT_W-1:0]             win_idx;
	logic [EW-1:0]                head_entry;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign has_room = tail_q < CNT_W'(QUEUE_DEPTH);
	assign issue    = rd_idx_q < tail_q;

	// Child k of a non-root expansion: bit 1 of k picks the u child, bit 0 the v child.
	always_comb begin
		cu_w    = '0;
		cv_w    = '0;
		keep    = 1'b0;
		last    = 1'b1;
		is_root = (u_q == '0) && (v_q == '0);
		if (op_q == bfqpq_pkg::OP_PUSH) begin
			cu_w = {1'b0, u_q};
			cv_w = {1'b0, v_q};
			keep = 1'b1;
		end else if (is_root) begin
			case (k_q)
				2'd0: begin
					cu_w = (COORD_BITS + 1)'(1);
					cv_w = '0;
				end
				2'd1: begin
					cu_w = '0;
					cv_w = (COORD_BITS + 1)'(1);
				end
				default: begin
					cu_w = (COORD_BITS + 1)'(1);
					cv_w = (COORD_BITS + 1)'(1);
				end
			endcase
			keep = 1'b1;
			last = k_q == 2'd2;
		end else begin
			cu_w = (u_q == '0) ? '0 : {u_q, k_q[1]};
			cv_w = (v_q == '0) ? '0 : {v_q, k_q[0]};
			// A zero axis has only one child, so its second pick is skipped.
			keep = !((u_q == '0) && k_q[1]) && !((v_q == '0) && k_q[0]) &&
				!cu_w[COORD_BITS] && !cv_w[COORD_BITS] &&
				(CMP_W'(cu_w) < CMP_W'(res_q)) && (CMP_W'(cv_w) < CMP_W'(res_q));
			last = k_q == 2'd3;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q[ADDR_W-1:0];
		ram_wdata = {cu_w[COORD_BITS-1:0], cv_w[COORD_BITS-1:0], prio_q};
		if (state_q == ST_EXPAND) begin
			ram_we = keep && has_room;
		end else if (state_q == ST_MOVE) begin
			ram_we    = 1'b1;
			ram_waddr = win_idx[ADDR_W-1:0];
			ram_wdata = head_entry;
		end
	end

	bfqpq_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign cmp_ctl.en   = pend_q;
	assign cmp_ctl.load = first_q;

	bfqpq_best #(
		.EW (EW),
		.PW (PRIORITY_BITS),
		.IW (CNT_W)
	) u_best (
		.clk        (clk),
		.ctl        (cmp_ctl),
		.entry      (ram_rdata),
		.idx        (pend_idx_q),
		.best_entry (best_entry),
		.win_idx    (win_idx),
		.head_entry (head_entry)
	);

	// Sequencer and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			res_q    <= bfqpq_pkg::RES_RESET;
			k_q      <= '0;
			rd_idx_q <= '0;
			pend_q   <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				res_q <= cfg_wdata;
			end
			pend_q <= 1'b0;
			if (pend_q) begin
				first_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q <= '0;
						case (bfqpq_pkg::op_t'(req.operation))
							bfqpq_pkg::OP_CLEAR: begin
								head_q  <= '0;
								tail_q  <= '0;
								state_q <= ST_FIN;
							end
							bfqpq_pkg::OP_PUSH, bfqpq_pkg::OP_EXPAND: begin
								state_q <= ST_EXPAND;
							end
							default: begin
								if (head_q < tail_q) begin
									rd_idx_q <= head_q;
									first_q  <= 1'b1;
									state_q  <= ST_SCAN;
								end else begin
									state_q <= ST_FIN;
								end
							end
						endcase
					end
				end
				ST_EXPAND: begin
					if (keep && has_room) begin
						tail_q <= tail_q + CNT_W'(1);
					end
					k_q <= k_q + 2'd1;
					if (last) begin
						state_q <= ST_FIN;
					end
				end
				ST_SCAN: begin
					// One read issued per cycle; its compare lands in the following cycle.
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
						pend_q   <= 1'b1;
					end else begin
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					head_q  <= head_q + CNT_W'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-request working values.
	always_ff @(posedge clk) begin
		pend_idx_q <= rd_idx_q;
		if (accept) begin
			op_q    <= bfqpq_pkg::op_t'(req.operation);
			u_q     <= req.node_u;
			v_q     <= req.node_v;
			prio_q  <= req.priority_req;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			valid_q <= 1'b0;
		end
		if (state_q == ST_EXPAND && keep) begin
			if (has_room) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
		if (state_q == ST_MOVE) begin
			valid_q <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			rsp_u_q      <= valid_q ? best_entry[EW-1 -: COORD_BITS] : '0;
			rsp_v_q      <= valid_q ? best_entry[PRIORITY_BITS +: COORD_BITS] : '0;
			rsp_prio_q   <= valid_q ? best_entry[PRIORITY_BITS-1:0] : '0;
			rsp_ovalid_q <= valid_q;
			rsp_empty_q  <= head_q == tail_q;
			rsp_cnt_q    <= cnt_q;
			rsp_drop_q   <= drop_q;
		end
	end

	assign req.ready        = state_q == ST_IDLE;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.out_u        = rsp_u_q;
	assign rsp.out_v        = rsp_v_q;
	assign rsp.out_priority = rsp_prio_q;
	assign rsp.out_valid    = rsp_ovalid_q;
	assign rsp.queue_empty  = rsp_empty_q;
	assign rsp.pushed_count = rsp_cnt_q;
	assign rsp.dropped      = rsp_drop_q;

	`BFQPQ_ASSERT_HOLDS(a_head_le_tail, clk, arst_n, head_q <= tail_q, "head passed tail")
	`BFQPQ_ASSERT_HOLDS(a_tail_bound, clk, arst_n, tail_q <= CNT_W'(QUEUE_DEPTH), "tail beyond store")
	`BFQPQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, state_q != ST_IDLE, "idle after accept")
	`BFQPQ_ASSERT_IMPLIES(a_pop_no_push, clk, arst_n, rsp.valid && rsp.out_valid, rsp.pushed_count == '0 && !rsp.dropped, "pop reported a push")

endmodule
